@@ sv/genome_compatibility_distance_core_macros.svh @@
// assertion macros shared by the compatibility distance core
`ifndef GENOME_COMPATIBILITY_DISTANCE_CORE_MACROS_SVH
`define GENOME_COMPATIBILITY_DISTANCE_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define GCDIST_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be seen outside reset
`define GCDIST_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define GCDIST_ASSERT(label, clk, rst_n, prop, msg)
`define GCDIST_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

@@ sv/gcdist_pkg.sv @@
// shared types and constants of the compatibility distance core
package gcdist_pkg;

	// coefficient registers, unsigned q8.8
	localparam int COEF_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_EXCESS_COEF = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DISJOINT_COEF = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_COEF = 2'd2;
	localparam logic [COEF_W-1:0] RST_EXCESS_COEF = 16'd256;
	localparam logic [COEF_W-1:0] RST_DISJOINT_COEF = 16'd256;
	localparam logic [COEF_W-1:0] RST_WEIGHT_COEF = 16'd102;

	// weight difference accumulator saturates at all ones
	localparam int DIFF_W = 47;
	localparam logic [DIFF_W-1:0] DIFF_MAX = '1;

	// distance output, unsigned q16.16
	localparam int DIST_W = 32;
	localparam int FLAG_W = 2;
	localparam int IN_USER_W = 2;

	// shared multiplier: 24 bit operand times coefficient
	localparam int MUL_A_W = 24;
	localparam int MUL_P_W = MUL_A_W + COEF_W;
	localparam int LO_W = 24;
	localparam int HI_W = DIFF_W - LO_W;

	// divider dividend width and scaling of the structural term
	localparam int DIV_W = 64;
	localparam int NUM_SHIFT = 8;

	typedef enum logic [1:0] {
		MUL_EXCESS,
		MUL_DISJOINT,
		MUL_WEIGHT_LO,
		MUL_WEIGHT_HI
	} mul_op_t;

	// controller to datapath
	typedef struct packed {
		logic    count_en;
		logic    mul_en;
		mul_op_t mul_op;
		logic    div_start;
		logic    div_weight;
		logic    term_load;
		logic    out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic empty;
		logic nomatch;
		logic div_busy;
		logic div_done;
	} stat_t;

endpackage

@@ sv/genome_compatibility_distance_core.sv @@
// Compatibility distance between two genomes, streamed one innovation index per transfer.
// Input stream: s_tdata holds both gene weights, s_tuser the two presence bits and s_tlast
// marks the highest innovation index of either genome. Each non-final transfer leaves the input
// ready, so a run of items streams at one per clock.
// After the final transfer the input stays not ready while the distance is computed: two
// products through a shared 24x16 multiplier, then a 64 step restoring divider for the
// structural term and, when genes matched, two more products and a second 64 step divide.
// When neither genome had a gene, both divides are skipped.
// Output stream: one transfer per genome pair with the q16.16 distance and the gene counts
// in m_tdata and the no-match and both-empty flags in m_tuser. The result waits in its
// register while the receiver stalls; the next pair's items are taken meanwhile, and only
// the following result waits for the register to empty.
// Config channel: writes to the three coefficients are always accepted; an unused index is
// ignored. Reset returns the coefficients to their defaults and clears all counters.
`include "genome_compatibility_distance_core_macros.svh"

module genome_compatibility_distance_core
	import gcdist_pkg::*;
#(
	parameter int MAX_GENES   = 4096,
	parameter int WEIGHT_BITS = 16,
	parameter int CNT_W       = $clog2(MAX_GENES + 1),
	parameter int IN_W        = ((2 * WEIGHT_BITS + 7) / 8) * 8,
	parameter int OUT_W       = ((DIST_W + 3 * CNT_W + 7) / 8) * 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_W-1:0]      s_tdata,   // first_weight, second_weight
	input  logic [IN_USER_W-1:0] s_tuser,   // first_present, second_present
	input  logic                 s_tlast,   // final_index
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [OUT_W-1:0]     m_tdata,   // distance, excess_total, disjoint_total,
	                                        // matching_total
	output logic [FLAG_W-1:0]    m_tuser,   // no_matching, both_empty
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COEF_W-1:0]    cfg_data
);

	cmd_t                   cmd;
	stat_t                  stat;
	logic [DIST_W-1:0]      distance;
	logic [CNT_W-1:0]       excess_total;
	logic [CNT_W-1:0]       disjoint_total;
	logic [CNT_W-1:0]       matching_total;
	logic                   no_matching;
	logic                   both_empty;

	assign cfg_ready = 1'b1;

	gcdist_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.m_tready (m_tready),
		.stat     (stat),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.cmd      (cmd)
	);

	gcdist_dp #(
		.MAX_GENES   (MAX_GENES),
		.WEIGHT_BITS (WEIGHT_BITS),
		.CNT_W       (CNT_W)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.first_present  (s_tuser[0]),
		.second_present (s_tuser[1]),
		.first_weight   (s_tdata[WEIGHT_BITS-1:0]),
		.second_weight  (s_tdata[2*WEIGHT_BITS-1:WEIGHT_BITS]),
		.distance       (distance),
		.excess_total   (excess_total),
		.disjoint_total (disjoint_total),
		.matching_total (matching_total),
		.no_matching    (no_matching),
		.both_empty     (both_empty)
	);

	// result packing, lowest field first
	assign m_tdata = OUT_W'({matching_total, disjoint_total, excess_total, distance});
	assign m_tuser = {both_empty, no_matching};

	// final transfer closes the input until the result is formed
	`GCDIST_ASSERT(a_last_closes_input, clk, arst_n, s_tvalid && s_tready && s_tlast |=> !s_tready, "input still open after final transfer")
	// a result never overwrites one the receiver has not taken
	`GCDIST_NEVER(a_no_result_overwrite, clk, arst_n, cmd.out_load && m_tvalid && !m_tready, "result register overwritten")
	// the divider is only started when idle
	`GCDIST_NEVER(a_div_start_idle, clk, arst_n, cmd.div_start && stat.div_busy, "divider restarted while busy")
	// an empty pair gives zero distance and no matches
	`GCDIST_ASSERT(a_empty_zero, clk, arst_n, m_tvalid && m_tuser[1] |-> (m_tdata[DIST_W-1:0] == '0) && m_tuser[0], "empty pair with nonzero distance")

endmodule

@@ sv/gcdist_div.sv @@
// restoring divider, one quotient bit per cycle
module gcdist_div
	import gcdist_pkg::*;
#(
	parameter int DVS_W = 15
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_W-1:0]  dividend,
	input  logic [DVS_W-1:0]  divisor,
	output logic              busy,
	output logic              done,
	output logic [DIV_W-1:0]  quotient
);

	localparam int CNT_W = $clog2(DIV_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;

	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   trial_sub;
	logic             fits;

	// shift in the next dividend bit and try the subtraction
	always_comb begin
		trial     = {rem_q, quo_q[DIV_W-1]};
		trial_sub = trial - {1'b0, dvs_q};
		fits      = trial >= {1'b0, dvs_q};
	end

	// control of the iteration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient and remainder registers
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], fits};
			rem_q <= fits ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ sv/gcdist_dp.sv @@
// datapath: gene counters, coefficients, multiplier, divider and result register
module gcdist_dp
	import gcdist_pkg::*;
#(
	parameter int MAX_GENES   = 4096,
	parameter int WEIGHT_BITS = 16,
	parameter int CNT_W       = 13
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cmd_t                    cmd,
	output stat_t                   stat,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [COEF_W-1:0]       cfg_data,
	input  logic                    first_present,
	input  logic                    second_present,
	input  logic [WEIGHT_BITS-1:0]  first_weight,
	input  logic [WEIGHT_BITS-1:0]  second_weight,
	output logic [DIST_W-1:0]       distance,
	output logic [CNT_W-1:0]        excess_total,
	output logic [CNT_W-1:0]        disjoint_total,
	output logic [CNT_W-1:0]        matching_total,
	output logic                    no_matching,
	output logic                    both_empty
);

	localparam int DVS_W = CNT_W + 2;
	localparam logic [CNT_W:0] MAX_CNT = (CNT_W + 1)'(MAX_GENES);

	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
			input logic [CNT_W-1:0] b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s > MAX_CNT) ? MAX_CNT[CNT_W-1:0] : s[CNT_W-1:0];
	endfunction

	logic [COEF_W-1:0] excess_coef_q;
	logic [COEF_W-1:0] disjoint_coef_q;
	logic [COEF_W-1:0] weight_coef_q;

	logic [CNT_W-1:0]  first_cnt_q;
	logic [CNT_W-1:0]  second_cnt_q;
	logic [CNT_W-1:0]  match_cnt_q;
	logic [CNT_W-1:0]  disj_cnt_q;
	logic [CNT_W-1:0]  pend_first_q;
	logic [CNT_W-1:0]  pend_second_q;
	logic [DIFF_W-1:0] diff_sum_q;

	logic [CNT_W-1:0]  first_cnt_d;
	logic [CNT_W-1:0]  second_cnt_d;
	logic [CNT_W-1:0]  match_cnt_d;
	logic [CNT_W-1:0]  disj_cnt_d;
	logic [CNT_W-1:0]  pend_first_d;
	logic [CNT_W-1:0]  pend_second_d;
	logic [DIFF_W-1:0] diff_sum_d;

	logic signed [WEIGHT_BITS:0] wdiff;
	logic [WEIGHT_BITS:0]        wabs;
	logic [DIFF_W:0]             diff_ext;

	logic [CNT_W-1:0]   excess;
	logic [CNT_W-1:0]   larger_cnt;
	logic               empty;
	logic               nomatch;

	logic [MUL_A_W-1:0] mul_a;
	logic [COEF_W-1:0]  mul_b;
	logic [MUL_P_W-1:0] mul_p;
	logic [DIV_W-1:0]   acc_q;
	logic [DIV_W-1:0]   term_q;

	logic [DIV_W-1:0]   div_dividend;
	logic [DVS_W-1:0]   div_divisor;
	logic [DIV_W-1:0]   div_quotient;
	logic               div_busy;
	logic               div_done;

	logic [DIV_W:0]     dist_sum;
	logic [DIST_W-1:0]  dist_sat;

	// coefficient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			excess_coef_q   <= RST_EXCESS_COEF;
			disjoint_coef_q <= RST_DISJOINT_COEF;
			weight_coef_q   <= RST_WEIGHT_COEF;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_EXCESS_COEF:   excess_coef_q   <= cfg_data;
				REG_DISJOINT_COEF: disjoint_coef_q <= cfg_data;
				REG_WEIGHT_COEF:   weight_coef_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// absolute weight difference of a matching gene
	always_comb begin
		wdiff    = $signed({first_weight[WEIGHT_BITS-1], first_weight})
			- $signed({second_weight[WEIGHT_BITS-1], second_weight});
		wabs     = wdiff[WEIGHT_BITS] ? (WEIGHT_BITS + 1)'(-wdiff) : wdiff;
		diff_ext = {1'b0, diff_sum_q} + (DIFF_W + 1)'(wabs);
	end

	// per innovation index counter update
	always_comb begin
		first_cnt_d   = first_cnt_q;
		second_cnt_d  = second_cnt_q;
		match_cnt_d   = match_cnt_q;
		disj_cnt_d    = disj_cnt_q;
		pend_first_d  = pend_first_q;
		pend_second_d = pend_second_q;
		diff_sum_d    = diff_sum_q;
		// a gene of one genome turns the other's pending genes disjoint
		if (first_present) begin
			first_cnt_d   = sat_add(first_cnt_q, CNT_W'(1));
			disj_cnt_d    = sat_add(disj_cnt_d, pend_second_q);
			pend_second_d = '0;
		end
		if (second_present) begin
			second_cnt_d = sat_add(second_cnt_q, CNT_W'(1));
			disj_cnt_d   = sat_add(disj_cnt_d, pend_first_q);
			pend_first_d = '0;
		end
		if (first_present && second_present) begin
			match_cnt_d = sat_add(match_cnt_q, CNT_W'(1));
			diff_sum_d  = diff_ext[DIFF_W] ? DIFF_MAX : diff_ext[DIFF_W-1:0];
		end else if (first_present) begin
			pend_first_d = sat_add(pend_first_q, CNT_W'(1));
		end else if (second_present) begin
			pend_second_d = sat_add(pend_second_q, CNT_W'(1));
		end
	end

	// counters, cleared once the result is taken into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_cnt_q   <= '0;
			second_cnt_q  <= '0;
			match_cnt_q   <= '0;
			disj_cnt_q    <= '0;
			pend_first_q  <= '0;
			pend_second_q <= '0;
			diff_sum_q    <= '0;
		end else if (cmd.out_load) begin
			first_cnt_q   <= '0;
			second_cnt_q  <= '0;
			match_cnt_q   <= '0;
			disj_cnt_q    <= '0;
			pend_first_q  <= '0;
			pend_second_q <= '0;
			diff_sum_q    <= '0;
		end else if (cmd.count_en) begin
			first_cnt_q   <= first_cnt_d;
			second_cnt_q  <= second_cnt_d;
			match_cnt_q   <= match_cnt_d;
			disj_cnt_q    <= disj_cnt_d;
			pend_first_q  <= pend_first_d;
			pend_second_q <= pend_second_d;
			diff_sum_q    <= diff_sum_d;
		end
	end

	// end of genome summary values
	always_comb begin
		excess     = sat_add(pend_first_q, pend_second_q);
		larger_cnt = (first_cnt_q > second_cnt_q) ? first_cnt_q : second_cnt_q;
		empty      = (larger_cnt == '0);
		nomatch    = (match_cnt_q == '0);
	end

	// operand selection for the shared multiplier
	always_comb begin
		case (cmd.mul_op)
			MUL_EXCESS: begin
				mul_a = MUL_A_W'(excess);
				mul_b = excess_coef_q;
			end
			MUL_DISJOINT: begin
				mul_a = MUL_A_W'(disj_cnt_q);
				mul_b = disjoint_coef_q;
			end
			MUL_WEIGHT_LO: begin
				mul_a = diff_sum_q[LO_W-1:0];
				mul_b = weight_coef_q;
			end
			MUL_WEIGHT_HI: begin
				mul_a = MUL_A_W'(diff_sum_q[DIFF_W-1:LO_W]);
				mul_b = weight_coef_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
	end

	// product accumulator
	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			case (cmd.mul_op)
				MUL_EXCESS:    acc_q <= DIV_W'(mul_p);
				MUL_DISJOINT:  acc_q <= acc_q + DIV_W'(mul_p);
				MUL_WEIGHT_LO: acc_q <= DIV_W'(mul_p);
				MUL_WEIGHT_HI: acc_q <= acc_q + DIV_W'({mul_p, {LO_W{1'b0}}});
				default:       acc_q <= acc_q;
			endcase
		end
	end

	// divider operands: structural term over larger count, weight term over 4*matches
	always_comb begin
		if (cmd.div_weight) begin
			div_dividend = acc_q;
			div_divisor  = {match_cnt_q, 2'b00};
		end else begin
			div_dividend = DIV_W'(acc_q << NUM_SHIFT);
			div_divisor  = DVS_W'(larger_cnt);
		end
	end

	gcdist_div #(
		.DVS_W (DVS_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quotient)
	);

	// first quotient kept while the weight term is worked out
	always_ff @(posedge clk) begin
		if (cmd.term_load) begin
			term_q <= div_quotient;
		end
	end

	// add the two terms (the weight term only when genes matched) and saturate; zero when empty
	always_comb begin
		dist_sum = {1'b0, term_q} + (nomatch ? '0 : {1'b0, div_quotient});
		if (empty) begin
			dist_sat = '0;
		end else if (dist_sum[DIV_W:DIST_W] != '0) begin
			dist_sat = '1;
		end else begin
			dist_sat = dist_sum[DIST_W-1:0];
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			distance       <= dist_sat;
			excess_total   <= excess;
			disjoint_total <= disj_cnt_q;
			matching_total <= match_cnt_q;
			no_matching    <= nomatch;
			both_empty     <= empty;
		end
	end

	assign stat.empty    = empty;
	assign stat.nomatch  = nomatch;
	assign stat.div_busy = div_busy;
	assign stat.div_done = div_done;

endmodule

@@ sv/gcdist_ctrl.sv @@
// controller: sequences the end of genome arithmetic and the output handshake
module gcdist_ctrl
	import gcdist_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s_tvalid,
	input  logic  s_tlast,
	input  logic  m_tready,
	input  stat_t stat,
	output logic  s_tready,
	output logic  m_tvalid,
	output cmd_t  cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_E,
		ST_MUL_D,
		ST_START_N,
		ST_WAIT_N,
		ST_MUL_WLO,
		ST_MUL_WHI,
		ST_START_M,
		ST_WAIT_M,
		ST_DONE
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   m_tvalid_q;
	logic   accept;
	logic   out_free;

	assign accept   = s_tvalid && (state_q == ST_IDLE);
	assign out_free = !m_tvalid_q || m_tready;

	// next state and commands
	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.mul_op     = MUL_EXCESS;
		cmd.count_en   = accept;
		case (state_q)
			ST_IDLE: begin
				if (accept && s_tlast) begin
					state_d = ST_MUL_E;
				end
			end
			ST_MUL_E: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = MUL_EXCESS;
				state_d    = stat.empty ? ST_DONE : ST_MUL_D;
			end
			ST_MUL_D: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = MUL_DISJOINT;
				state_d    = ST_START_N;
			end
			ST_START_N: begin
				cmd.div_start = 1'b1;
				state_d       = ST_WAIT_N;
			end
			ST_WAIT_N: begin
				if (stat.div_done) begin
					cmd.term_load = 1'b1;
					state_d       = stat.nomatch ? ST_DONE : ST_MUL_WLO;
				end
			end
			ST_MUL_WLO: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = MUL_WEIGHT_LO;
				state_d    = ST_MUL_WHI;
			end
			ST_MUL_WHI: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = MUL_WEIGHT_HI;
				state_d    = ST_START_M;
			end
			ST_START_M: begin
				cmd.div_start  = 1'b1;
				cmd.div_weight = 1'b1;
				state_d        = ST_WAIT_M;
			end
			ST_WAIT_M: begin
				cmd.div_weight = 1'b1;
				if (stat.div_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				// hold until the output register is free
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;

endmodule
